// ===== sv/sptc_pkg.sv =====
// Shared types, codes and the CRC step for the telecommand packet checker.
package sptc_pkg;

	localparam int APID_DEPTH = 2048;
	localparam int APID_W     = 11;
	localparam int IDX_W      = 17;

	localparam logic [16:0] MIN_LEN  = 17'd9;
	localparam logic [16:0] IDX_SAT  = 17'h10000;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [2:0]  PVN_TC   = 3'd1;

	localparam logic [1:0] OP_BYTE      = 2'd0;
	localparam logic [1:0] OP_CLEAR_ONE = 2'd1;
	localparam logic [1:0] OP_CLEAR_ALL = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_VERSION   = 3'd2;
	localparam logic [2:0] ST_TYPE      = 3'd3;
	localparam logic [2:0] ST_CRC       = 3'd4;
	localparam logic [2:0] ST_REPLAY    = 3'd5;
	localparam logic [2:0] ST_TOO_LONG  = 3'd6;

	localparam logic [3:0] OFS_PLAIN = 4'd6;
	localparam logic [3:0] OFS_SEC   = 4'd10;

	typedef struct packed {
		logic [1:0]        op;
		logic [7:0]        data_byte;
		logic              last_byte;
		logic [APID_W-1:0] clear_apid;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [APID_W-1:0] apid;
		logic              sec_hdr;
		logic [1:0]        seq_flags;
		logic [13:0]       seq_count;
		logic [15:0]       pkt_data_len;
		logic [15:0]       body_len;
		logic [3:0]        payload_offset;
		logic              sequence_gap;
	} rsp_t;

	// One history entry: seen flag over the last accepted count.
	typedef struct packed {
		logic        seen;
		logic [13:0] count;
	} hist_ent_t;

	typedef struct packed {
		logic              en;
		logic [APID_W-1:0] addr;
		hist_ent_t         data;
	} hist_wr_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== sv/sptc_hist.sv =====
// Per-APID sequence history memory with a clearing sweep.
module sptc_hist #(
	parameter int APID_TABLE_DEPTH = sptc_pkg::APID_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         clear_all,
	input  logic                         rd_en,
	input  logic [sptc_pkg::APID_W-1:0]  rd_addr,
	output sptc_pkg::hist_ent_t          rd_data,
	input  sptc_pkg::hist_wr_t           wr,
	output logic                         busy
);
	import sptc_pkg::*;

	localparam int AW = $clog2(APID_TABLE_DEPTH);

	hist_ent_t         mem [APID_TABLE_DEPTH];
	logic              busy_q;
	logic [AW-1:0]     ptr_q;
	logic              we;
	logic [AW-1:0]     wa;
	hist_ent_t         wd;

	assign busy = busy_q;

	// Sweep every entry after reset and after a clear-all command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			ptr_q  <= '0;
		end else if (clear_all) begin
			busy_q <= 1'b1;
			ptr_q  <= '0;
		end else if (busy_q) begin
			ptr_q <= ptr_q + 1'b1;
			if (ptr_q == AW'(APID_TABLE_DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (busy_q) begin
			we = 1'b1;
			wa = ptr_q;
			wd = '0;
		end else begin
			we = wr.en;
			wa = wr.addr[AW-1:0];
			wd = wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr[AW-1:0]];
		end
	end

endmodule

// ===== sv/space_packet_telecommand_checker_core.sv =====
// Top level of the space packet telecommand checker.
//
// Request channel (req_valid/req_stall/req): one transfer per command or packet
// byte. Packet bytes (op 0) arrive in order; last_byte marks the final one.
// Op 1 clears the history of one APID, op 2 clears all histories; op 3 is
// ignored. Response channel (rsp_valid/rsp_stall/rsp): one transfer per
// packet, carrying status and header fields; failed packets report zeros.
// Throughput is one request per cycle while req_stall is low. When the last
// byte of a packet is taken, the APID history memory is read into the check
// stage; the checked result then loads into the output register while the
// history entry is updated in the same pass.
// After reset and after each clear-all command the history memory is swept
// one entry per cycle, all APID_TABLE_DEPTH entries (2048 by default);
// req_stall stays high during the sweep.
// When the receiver stalls, the pending response holds in the output register
// and one more finished packet may wait in the check stage; only then is
// req_stall raised.
module space_packet_telecommand_checker_core #(
	parameter int APID_TABLE_DEPTH = sptc_pkg::APID_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  sptc_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sptc_pkg::rsp_t rsp
);
	import sptc_pkg::*;

	// packet assembly state
	logic [15:0]      crc_q;
	logic [IDX_W-1:0] idx_q;
	logic [47:0]      hdr_q;
	logic [15:0]      tail_q;

	logic [15:0]      crc_nx;
	logic [IDX_W-1:0] idx_nx;
	logic [47:0]      hdr_nx;
	logic [15:0]      tail_nx;

	// check stage
	logic              valid_s1;
	logic              pkt_s1;
	logic [APID_W-1:0] clr_s1;
	logic [47:0]       hdr_s1;
	logic [15:0]       crc_s1;
	logic [15:0]       tail_s1;
	logic              long_s1;
	logic              short_s1;
	logic              byp_s1;
	hist_ent_t         bypd_s1;

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic        accept;
	logic        take_byte;
	logic        take_s1;
	logic        adv_s1;
	logic        busy;
	hist_ent_t   rd_data;
	hist_ent_t   ent;
	hist_wr_t    wr;
	rsp_t        res;
	logic [2:0]  status;
	logic [7:0]  b0;
	logic [APID_W-1:0] rd_addr;

	assign adv_s1    = !valid_s1 || !pkt_s1 || !rsp_valid_q || !rsp_stall;
	assign req_stall = busy || !adv_s1;
	assign accept    = req_valid && !req_stall;
	assign take_byte = accept && (req.op == OP_BYTE);
	assign take_s1   = accept && ((req.op == OP_CLEAR_ONE) ||
		((req.op == OP_BYTE) && req.last_byte));

	// byte assembly
	always_comb begin
		idx_nx  = (idx_q != IDX_SAT) ? idx_q + 1'b1 : idx_q;
		crc_nx  = (idx_q >= IDX_W'(2)) ? crc_byte(crc_q, tail_q[15:8]) : crc_q;
		tail_nx = {tail_q[7:0], req.data_byte};
		hdr_nx  = hdr_q;
		if (idx_q < IDX_W'(6)) begin
			unique case (idx_q[2:0])
				3'd0:    hdr_nx[47:40] = req.data_byte;
				3'd1:    hdr_nx[39:32] = req.data_byte;
				3'd2:    hdr_nx[31:24] = req.data_byte;
				3'd3:    hdr_nx[23:16] = req.data_byte;
				3'd4:    hdr_nx[15:8]  = req.data_byte;
				default: hdr_nx[7:0]   = req.data_byte;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			idx_q  <= '0;
			hdr_q  <= '0;
			tail_q <= '0;
		end else if (take_byte) begin
			if (req.last_byte) begin
				crc_q  <= CRC_INIT;
				idx_q  <= '0;
				hdr_q  <= '0;
				tail_q <= '0;
			end else begin
				crc_q  <= crc_nx;
				idx_q  <= idx_nx;
				hdr_q  <= hdr_nx;
				tail_q <= tail_nx;
			end
		end
	end

	assign rd_addr = (req.op == OP_BYTE) ? {hdr_nx[42:40], hdr_nx[39:32]} : req.clear_apid;

	sptc_hist #(
		.APID_TABLE_DEPTH(APID_TABLE_DEPTH)
	) u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear_all (accept && (req.op == OP_CLEAR_ALL)),
		.rd_en     (take_s1),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr        (wr),
		.busy      (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= take_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			pkt_s1   <= (req.op == OP_BYTE);
			clr_s1   <= req.clear_apid;
			hdr_s1   <= hdr_nx;
			crc_s1   <= crc_nx;
			tail_s1  <= tail_nx;
			long_s1  <= idx_nx[IDX_W-1];
			short_s1 <= idx_nx < MIN_LEN;
			// forward the entry written by the older item in this same cycle
			byp_s1   <= wr.en && (wr.addr == rd_addr);
			bypd_s1  <= wr.data;
		end
	end

	// check and history update
	always_comb begin
		logic [14:0] next_cnt;
		ent      = byp_s1 ? bypd_s1 : rd_data;
		b0       = hdr_s1[47:40];
		res      = '0;
		next_cnt = {1'b0, ent.count} + 15'd1;
		res.apid           = {b0[2:0], hdr_s1[39:32]};
		res.sec_hdr        = b0[3];
		res.seq_flags      = hdr_s1[31:30];
		res.seq_count      = hdr_s1[29:16];
		res.pkt_data_len   = hdr_s1[15:0];
		res.body_len       = hdr_s1[15:0] - 16'd1;
		res.payload_offset = b0[3] ? OFS_SEC : OFS_PLAIN;
		res.sequence_gap   = ent.seen && ({1'b0, hdr_s1[29:16]} > next_cnt);
		priority if (long_s1) begin
			status = ST_TOO_LONG;
		end else if (short_s1) begin
			status = ST_SHORT;
		end else if (b0[7:5] != PVN_TC) begin
			status = ST_VERSION;
		end else if (!b0[4]) begin
			status = ST_TYPE;
		end else if (crc_s1 != tail_s1) begin
			status = ST_CRC;
		end else if (ent.seen && (hdr_s1[29:16] <= ent.count)) begin
			status = ST_REPLAY;
		end else begin
			status = ST_OK;
		end
		if (status != ST_OK) begin
			res = '0;
		end
		res.status = status;

		wr.en   = valid_s1 && adv_s1 && (!pkt_s1 || (status == ST_OK));
		wr.addr = pkt_s1 ? res.apid : clr_s1;
		wr.data.seen  = pkt_s1;
		wr.data.count = pkt_s1 ? hdr_s1[29:16] : 14'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (valid_s1 && pkt_s1 && adv_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && pkt_s1 && adv_s1) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== sv/sptc_checker.sv =====
// Port-level assertions for the telecommand checker, bound to the top level.
module sptc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input sptc_pkg::rsp_t rsp
);
	import sptc_pkg::*;

	// hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp))
		else $error("stalled response changed");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |->
		(rsp.apid == '0) && (rsp.seq_count == '0) && (rsp.pkt_data_len == '0) &&
		(rsp.payload_offset == '0) && !rsp.sequence_gap)
		else $error("failed packet carries header fields");

	a_ok_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_OK) |->
		(rsp.body_len == rsp.pkt_data_len - 16'd1) &&
		(rsp.payload_offset == (rsp.sec_hdr ? OFS_SEC : OFS_PLAIN)))
		else $error("derived payload fields inconsistent");

endmodule

bind space_packet_telecommand_checker_core sptc_checker u_sptc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
